@@ design/robd_pkg.sv @@
// Shared types, constants and tables for the relocatable object bit-stream decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package robd_pkg;

    localparam int NAME_MAX_CHARS = 7;
    localparam int NAME_BITS      = 56;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_CODE  = 3'd2;
    localparam logic [2:0] PH_ATYPE = 3'd3;
    localparam logic [2:0] PH_VALUE = 3'd4;
    localparam logic [2:0] PH_NLEN  = 3'd5;
    localparam logic [2:0] PH_NAME  = 3'd6;
    localparam logic [2:0] PH_ABS   = 3'd7;

    localparam logic [3:0] K_ABS     = 4'd0;
    localparam logic [3:0] K_PREL    = 4'd1;
    localparam logic [3:0] K_DREL    = 4'd2;
    localparam logic [3:0] K_ENTSYM  = 4'd3;
    localparam logic [3:0] K_PNAME   = 4'd4;
    localparam logic [3:0] K_CHAIN   = 4'd5;
    localparam logic [3:0] K_ENTPT   = 4'd6;
    localparam logic [3:0] K_EXTOFS  = 4'd7;
    localparam logic [3:0] K_DSIZE   = 4'd8;
    localparam logic [3:0] K_SETLOC  = 4'd9;
    localparam logic [3:0] K_PSIZE   = 4'd10;
    localparam logic [3:0] K_ENDMOD  = 4'd11;
    localparam logic [3:0] K_ENDFILE = 4'd12;
    localparam logic [3:0] K_ERROR   = 4'd13;

    localparam logic [1:0] TYPE_SPECIAL = 2'd0;
    localparam logic [1:0] TYPE_PROG    = 2'd1;
    localparam logic [1:0] TYPE_BAD     = 2'd3;

    typedef struct packed {
        logic [2:0]           phase;
        logic [3:0]           bit_cnt;
        logic [15:0]          acc;
        logic [3:0]           kind;
        logic [1:0]           atype;
        logic [15:0]          value;
        logic [NAME_BITS-1:0] name_buf;
        logic [2:0]           name_count;
        logic [2:0]           chars_left;
        logic                 halted;
    } t_parse_state;

    typedef struct packed {
        logic [3:0]           kind;
        logic [1:0]           atype;
        logic [15:0]          value;
        logic [2:0]           name_len;
        logic [NAME_BITS-1:0] name_chars;
        logic                 last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic logic [4:0] field_len(input logic [2:0] phase);
        logic [4:0] len;
        unique case (phase)
            PH_LEAD:  len = 5'd1;
            PH_TYPE:  len = 5'd2;
            PH_CODE:  len = 5'd4;
            PH_ATYPE: len = 5'd2;
            PH_VALUE: len = 5'd16;
            PH_NLEN:  len = 5'd3;
            PH_NAME:  len = 5'd8;
            default:  len = 5'd8;
        endcase
        return len;
    endfunction

    function automatic logic [3:0] code_kind(input logic [3:0] code);
        logic [3:0] kind;
        unique case (code)
            4'd0:    kind = K_ENTSYM;
            4'd2:    kind = K_PNAME;
            4'd6:    kind = K_CHAIN;
            4'd7:    kind = K_ENTPT;
            4'd9:    kind = K_EXTOFS;
            4'd10:   kind = K_DSIZE;
            4'd11:   kind = K_SETLOC;
            4'd13:   kind = K_PSIZE;
            4'd14:   kind = K_ENDMOD;
            4'd15:   kind = K_ENDFILE;
            default: kind = K_ERROR;
        endcase
        return kind;
    endfunction

endpackage
`default_nettype wire

@@ design/robd_bit_step.sv @@
// One bit step of the item parser: shifts in a bit, closes a field and advances the phase.
// Pure combinational logic; depends on robd_pkg.
`default_nettype none
module robd_bit_step
    import robd_pkg::*;
(
    input  t_parse_state i_state,
    input  logic         i_bit,
    input  logic         i_active,
    output t_parse_state o_state,
    output logic         o_active,
    output logic         o_emit,
    output t_token       o_token
);

    logic [15:0] acc_next;
    logic [4:0]  cnt_next;
    logic [15:0] v;

    always_comb begin
        o_state  = i_state;
        o_active = i_active;
        o_emit   = 1'b0;
        acc_next = {i_state.acc[14:0], i_bit};
        cnt_next = {1'b0, i_state.bit_cnt} + 5'd1;
        v        = acc_next;
        if (i_active) begin
            o_state.acc     = acc_next;
            o_state.bit_cnt = cnt_next[3:0];
            if (cnt_next >= field_len(i_state.phase)) begin
                o_state.acc     = '0;
                o_state.bit_cnt = '0;
                unique case (i_state.phase)
                    PH_LEAD: begin
                        o_state.kind       = K_ABS;
                        o_state.atype      = '0;
                        o_state.value      = '0;
                        o_state.name_buf   = '0;
                        o_state.name_count = '0;
                        o_state.chars_left = '0;
                        o_state.phase      = (v != 16'd0) ? PH_TYPE : PH_ABS;
                    end
                    PH_ABS: begin
                        o_state.kind  = K_ABS;
                        o_state.value = {8'd0, v[7:0]};
                        o_emit        = 1'b1;
                    end
                    PH_TYPE: begin
                        if (v[1:0] == TYPE_SPECIAL) begin
                            o_state.phase = PH_CODE;
                        end else if (v[1:0] == TYPE_BAD) begin
                            o_state.kind   = K_ERROR;
                            o_state.halted = 1'b1;
                            o_active       = 1'b0;
                            o_emit         = 1'b1;
                        end else begin
                            o_state.kind  = (v[1:0] == TYPE_PROG) ? K_PREL : K_DREL;
                            o_state.atype = v[1:0];
                            o_state.phase = PH_VALUE;
                        end
                    end
                    PH_CODE: begin
                        o_state.kind = code_kind(v[3:0]);
                        if (o_state.kind == K_ERROR) begin
                            o_state.halted = 1'b1;
                            o_active       = 1'b0;
                            o_emit         = 1'b1;
                        end else if (o_state.kind == K_ENDFILE) begin
                            o_emit = 1'b1;
                        end else if (o_state.kind == K_ENTSYM || o_state.kind == K_PNAME) begin
                            o_state.phase = PH_NLEN;
                        end else begin
                            o_state.phase = PH_ATYPE;
                        end
                    end
                    PH_ATYPE: begin
                        if (v[1:0] == TYPE_BAD) begin
                            o_state.kind       = K_ERROR;
                            o_state.atype      = '0;
                            o_state.value      = '0;
                            o_state.name_buf   = '0;
                            o_state.name_count = '0;
                            o_state.chars_left = '0;
                            o_state.halted     = 1'b1;
                            o_active           = 1'b0;
                            o_emit             = 1'b1;
                        end else begin
                            o_state.atype = v[1:0];
                            o_state.phase = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        o_state.value = {v[7:0], v[15:8]};
                        if (i_state.kind == K_CHAIN || i_state.kind == K_ENTPT) begin
                            o_state.phase = PH_NLEN;
                        end else begin
                            o_emit = 1'b1;
                            if (i_state.kind == K_ENDMOD) begin
                                o_active = 1'b0;
                            end
                        end
                    end
                    PH_NLEN: begin
                        if (v[2:0] == 3'd0) begin
                            o_emit = 1'b1;
                        end else begin
                            o_state.chars_left = v[2:0];
                            o_state.phase      = PH_NAME;
                        end
                    end
                    default: begin
                        if (i_state.name_count < 3'(NAME_MAX_CHARS)) begin
                            for (int j = 0; j < NAME_MAX_CHARS; j++) begin
                                if (i_state.name_count == 3'(j)) begin
                                    o_state.name_buf[8*j +: 8] = v[7:0];
                                end
                            end
                            o_state.name_count = i_state.name_count + 3'd1;
                        end
                        o_state.chars_left = i_state.chars_left - 3'd1;
                        if (o_state.chars_left == 3'd0) begin
                            o_emit = 1'b1;
                        end
                    end
                endcase
                if (o_emit) begin
                    o_state.phase = PH_LEAD;
                end
            end
        end
    end

    assign o_token = '{kind:       o_state.kind,
                       atype:      o_state.atype,
                       value:      o_state.value,
                       name_len:   o_state.name_count,
                       name_chars: o_state.name_buf,
                       last:       1'b0};

endmodule
`default_nettype wire

@@ design/robd_byte_decoder.sv @@
// Parser state register and the chain of eight bit steps that decode one byte per cycle while i_take is high.
// Depends on robd_pkg and robd_bit_step.
`default_nettype none
module robd_byte_decoder
    import robd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output t_push      o_push
);

    t_parse_state r_state;
    t_parse_state w_st [9];
    logic [8:0]   w_act;
    logic [7:0]   w_emit;
    t_token       w_tok [8];
    logic [1:0]   n_cnt;
    t_token       n_tok0;
    t_token       n_tok1;

    assign w_st[0]  = r_state;
    assign w_act[0] = ~r_state.halted;

    for (genvar k = 0; k < 8; k++) begin : g_step
        robd_bit_step u_step (
            .i_state  (w_st[k]),
            .i_bit    (i_byte[7-k]),
            .i_active (w_act[k]),
            .o_state  (w_st[k+1]),
            .o_active (w_act[k+1]),
            .o_emit   (w_emit[k]),
            .o_token  (w_tok[k])
        );
    end

    always_comb begin
        n_cnt  = 2'd0;
        n_tok0 = '0;
        n_tok1 = '0;
        for (int k = 0; k < 8; k++) begin
            if (w_emit[k]) begin
                if (n_cnt == 2'd0) begin
                    n_tok0 = w_tok[k];
                end else if (n_cnt == 2'd1) begin
                    n_tok1 = w_tok[k];
                end
                if (n_cnt != 2'd2) begin
                    n_cnt = n_cnt + 2'd1;
                end
            end
        end
        if (n_cnt == 2'd1) begin
            n_tok0.last = 1'b1;
        end
        if (n_cnt == 2'd2) begin
            n_tok1.last = 1'b1;
        end
    end

    assign o_push = '{count: i_take ? n_cnt : 2'd0, tok0: n_tok0, tok1: n_tok1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_LEAD, default: '0};
        end else if (i_take) begin
            r_state <= w_st[8];
        end
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |=> r_state.halted)
        else $error("Halted decoder resumed without reset.");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.halted |-> (o_push.count == 2'd0))
        else $error("Halted decoder produced a token.");

endmodule
`default_nettype wire

@@ design/robd_token_queue.sv @@
// Four-entry token queue that takes up to two tokens per cycle and delivers one per transfer.
// Depends on robd_pkg.
`default_nettype none
module robd_token_queue
    import robd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token
);

    t_token            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr1;
    logic              w_pop;

    assign o_valid   = (r_count != '0);
    assign o_token   = r_mem[r_rd_ptr];
    assign o_room    = (r_count <= QCNT_W'(QUEUE_DEPTH - 2));
    assign w_pop     = o_valid & i_ready;
    assign n_wr_ptr1 = r_wr_ptr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.tok0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[n_wr_ptr1] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QPTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(w_pop);
            r_count  <= r_count + QCNT_W'(i_push.count) - QCNT_W'(w_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= QCNT_W'(QUEUE_DEPTH - 2)))
        else $error("Token queue written without room.");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("Token queue count wrong after a lone transfer.");

endmodule
`default_nettype wire

@@ design/rel_object_bitstream_decoder.sv @@
// Top level of the relocatable object bit-stream decoder: input register, byte decoder
// and token queue. Depends on robd_pkg, robd_byte_decoder and robd_token_queue.
//
// Usage: object file bytes enter on i_valid/o_ready with i_data_byte, most significant
// bit first. Each completed item leaves as one token on o_valid/i_ready with its kind,
// address type, value, name length and name characters; o_last_of_byte marks the last
// token that a byte completed. A byte is captured in the input register, then decoded
// combinationally by eight chained bit steps, and its tokens are written to a
// four-entry queue whose head drives the outputs. One byte is taken every cycle while
// the queue has room; a byte that completes two tokens needs two output transfers.
// A byte is decoded only when the queue has room for two tokens, so a stalled
// receiver fills the queue and then holds o_ready low, with no token lost.
// Reset clears the parser to expect a lead bit, empties the queue and clears the
// halt flag. After a format error token the decoder accepts bytes but emits nothing
// more until reset.
`default_nettype none
module rel_object_bitstream_decoder
    import robd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_token_kind,
    output logic [1:0]           o_address_type,
    output logic [15:0]          o_item_value,
    output logic [2:0]           o_name_length,
    output logic [NAME_BITS-1:0] o_name_chars,
    output logic                 o_last_of_byte
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_room;
    logic       w_take;
    t_push      w_push;
    t_token     w_head;

    assign w_take  = r_in_valid & w_room;
    assign o_ready = ~r_in_valid | w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    robd_byte_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (r_in_byte),
        .o_push  (w_push)
    );

    robd_token_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_token (w_head)
    );

    assign o_token_kind   = w_head.kind;
    assign o_address_type = w_head.atype;
    assign o_item_value   = w_head.value;
    assign o_name_length  = w_head.name_len;
    assign o_name_chars   = w_head.name_chars;
    assign o_last_of_byte = w_head.last;

endmodule
`default_nettype wire
